### rtl/rau_pkg.sv
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  // Magnitudes of raw results, including the sum of two full products.
  localparam int MAG_W = PROD_W + 1;
  localparam int NUM_W = 32;
  localparam int DEN_W = 30;
  localparam int EXT_W = (MAG_W > NUM_W) ? MAG_W : NUM_W;
  localparam int CNT_W = $clog2(MAG_W + 1);

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_NEG = 3'd4;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/rau_div.sv
module rau_div (
  input  logic             clk,
  input  logic             rst,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);
  import rau_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] quo;
  logic [MAG_W-1:0] divisor;
  logic [MAG_W:0]   trial;
  logic [MAG_W+1:0] diff;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem, quo[MAG_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == CNT_W'(MAG_W - 1));
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        if (!diff[MAG_W+1]) begin
          rem <= diff[MAG_W-1:0];
        end else begin
          rem <= trial[MAG_W-1:0];
        end
        quo <= {quo[MAG_W-2:0], !diff[MAG_W+1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: combines two fractions under a command (add, subtract, multiply,
// divide, negate a, reduce a) and returns the result in lowest terms with a positive
// denominator; a zero raw denominator gives 0/1 with zero_den_error set. One request is
// worked on at a time and in_ready is high only while the unit is idle. A request goes
// through three products on the single shared multiplier, the forming of the raw fraction,
// binary GCD (one subtract and compare per cycle), two exact divisions on the shared
// bit-serial divider, and the loading of the output register. A zero raw denominator skips
// the GCD and divisions. A finished result waits in the output register while the next
// request is accepted; the following result then waits until the first one is taken.
module rational_arithmetic_unit_top (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [2:0]                               command,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_num,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_den,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_num,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_den,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [rau_pkg::NUM_W-1:0]         res_num,
  output logic [rau_pkg::DEN_W-1:0]                res_den,
  output logic                                     zero_den_error
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_FORM, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  localparam int OW = OPERAND_WIDTH;

  state_t state;

  logic [2:0]             cmd;
  logic signed [OW-1:0]   an, ad, bn, bd;
  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [OW-1:0]   m_x, m_y;
  logic signed [PROD_W-1:0] m_p;

  logic signed [MAG_W:0]  rn_w, rd_w;
  logic [MAG_W-1:0]       rn_abs, rd_abs;

  logic                   neg;
  logic                   err;
  logic [MAG_W-1:0]       mn, md, u, v;
  logic [CNT_W-1:0]       k;
  logic [MAG_W-1:0]       qn, qd;
  logic [EXT_W-1:0]       qn_ext, qd_ext, num_ext;

  logic                   div_start;
  logic [MAG_W-1:0]       div_dividend, div_divisor;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   out_free;

  // Shared multiplier: the operand pair depends on the step and the command.
  always_comb begin
    m_x = an;
    m_y = bd;
    case (state)
      S_MUL0: begin
        m_x = an;
        m_y = (cmd == CMD_MUL) ? bn : bd;
      end
      S_MUL1: begin
        m_x = ad;
        m_y = bn;
      end
      S_MUL2: begin
        m_x = ad;
        m_y = (cmd == CMD_DIV) ? bn : bd;
      end
      default: begin
        m_x = an;
        m_y = bd;
      end
    endcase
  end

  assign m_p = m_x * m_y;

  always_comb begin
    case (cmd)
      CMD_ADD: rn_w = {{2{p0[PROD_W-1]}}, p0} + {{2{p1[PROD_W-1]}}, p1};
      CMD_SUB: rn_w = {{2{p0[PROD_W-1]}}, p0} - {{2{p1[PROD_W-1]}}, p1};
      CMD_MUL: rn_w = {{2{p0[PROD_W-1]}}, p0};
      CMD_DIV: rn_w = {{2{p0[PROD_W-1]}}, p0};
      CMD_NEG: rn_w = -{{(MAG_W+1-OW){an[OW-1]}}, an};
      default: rn_w = {{(MAG_W+1-OW){an[OW-1]}}, an};
    endcase
    case (cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: rd_w = {{2{p2[PROD_W-1]}}, p2};
      default: rd_w = {{(MAG_W+1-OW){ad[OW-1]}}, ad};
    endcase
  end

  always_comb begin
    logic signed [MAG_W:0] rn_m, rd_m;
    rn_m   = rn_w[MAG_W] ? -rn_w : rn_w;
    rd_m   = rd_w[MAG_W] ? -rd_w : rd_w;
    rn_abs = rn_m[MAG_W-1:0];
    rd_abs = rd_m[MAG_W-1:0];
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  assign div_req.start    = div_start;
  assign div_req.dividend = div_dividend;
  assign div_req.divisor  = div_divisor;

  rau_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign qn_ext  = EXT_W'(qn);
  assign qd_ext  = EXT_W'(qd);
  assign num_ext = neg ? ('0 - qn_ext) : qn_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= ((state == S_GCD) && (u == '0)) || ((state == S_DIVN) && div_rsp.done);
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= command;
            an    <= a_num;
            ad    <= a_den;
            bn    <= b_num;
            bd    <= b_den;
            state <= S_MUL0;
          end
        end
        S_MUL0: begin
          p0    <= m_p;
          state <= S_MUL1;
        end
        S_MUL1: begin
          p1    <= m_p;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= m_p;
          state <= S_FORM;
        end
        S_FORM: begin
          if (rd_w == '0) begin
            err   <= 1'b1;
            neg   <= 1'b0;
            qn    <= '0;
            qd    <= MAG_W'(1);
            state <= S_DONE;
          end else begin
            err   <= 1'b0;
            neg   <= rn_w[MAG_W] ^ rd_w[MAG_W];
            mn    <= rn_abs;
            md    <= rd_abs;
            u     <= rn_abs;
            v     <= rd_abs;
            k     <= '0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // Binary GCD; the denominator side never reaches zero.
          if (u == '0) begin
            div_dividend <= mn;
            div_divisor  <= v << k;
            state        <= S_DIVN;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
        S_DIVN: begin
          if (div_rsp.done) begin
            qn           <= div_rsp.quotient;
            div_dividend <= md;
            state        <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_rsp.done) begin
            qd    <= div_rsp.quotient;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_num        <= num_ext[NUM_W-1:0];
            res_den        <= qd_ext[DEN_W-1:0];
            zero_den_error <= err;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### verif/rational_result_checker.sv
`timescale 1ns / 100ps

module rational_result_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  logic                                     in_ready,
  input  logic [2:0]                               command,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_num,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_den,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_num,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_den,
  input  logic                                     out_valid,
  input  logic                                     out_ready,
  input  logic signed [rau_pkg::NUM_W-1:0]         res_num,
  input  logic [rau_pkg::DEN_W-1:0]                res_den,
  input  logic                                     zero_den_error,
  output int                                       fail_count,
  output int                                       pending
);
  import rau_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic                    err;
  } fraction_t;

  fraction_t expected_fractions[$];

  // Exact arithmetic at 64 bits, then reduction by the Euclidean GCD.
  function automatic fraction_t reduce_to_lowest(
    input logic [2:0]                      cmd,
    input logic signed [OPERAND_WIDTH-1:0] an_in,
    input logic signed [OPERAND_WIDTH-1:0] ad_in,
    input logic signed [OPERAND_WIDTH-1:0] bn_in,
    input logic signed [OPERAND_WIDTH-1:0] bd_in
  );
    longint          an, ad, bn, bd, rn, rd;
    longint unsigned mn, md, p, q, r, signed_mag;
    logic            neg;
    fraction_t       f;
    an = an_in;
    ad = ad_in;
    bn = bn_in;
    bd = bd_in;
    case (cmd)
      CMD_ADD: begin
        rn = an * bd + ad * bn;
        rd = ad * bd;
      end
      CMD_SUB: begin
        rn = an * bd - ad * bn;
        rd = ad * bd;
      end
      CMD_MUL: begin
        rn = an * bn;
        rd = ad * bd;
      end
      CMD_DIV: begin
        rn = an * bd;
        rd = ad * bn;
      end
      CMD_NEG: begin
        rn = -an;
        rd = ad;
      end
      // Reduce, and the two spare codes that behave like it.
      default: begin
        rn = an;
        rd = ad;
      end
    endcase
    if (rd == 0) begin
      f.num = '0;
      f.den = DEN_W'(1);
      f.err = 1'b1;
      return f;
    end
    neg = (rn < 0) != (rd < 0);
    mn = (rn < 0) ? -rn : rn;
    md = (rd < 0) ? -rd : rd;
    p = mn;
    q = md;
    while (q != 0) begin
      r = p % q;
      p = q;
      q = r;
    end
    mn = mn / p;
    md = md / p;
    signed_mag = neg ? (64'd0 - mn) : mn;
    f.num = signed_mag[NUM_W-1:0];
    f.den = md[DEN_W-1:0];
    f.err = 1'b0;
    return f;
  endfunction

  always @(posedge clk) begin
    fraction_t want;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_fractions.push_back(reduce_to_lowest(command, a_num, a_den, b_num, b_den));
      end
      if (out_valid && out_ready) begin
        if (expected_fractions.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("%0t: result %0d/%0d err=%0b with no request outstanding",
                     $realtime, res_num, res_den, zero_den_error);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = expected_fractions.pop_front();
          if (res_num !== want.num || res_den !== want.den || zero_den_error !== want.err)
          begin
            if (fail_count < REPORT_LIMIT) begin
              $display("%0t: mismatch: expected %0d/%0d err=%0b, got %0d/%0d err=%0b",
                       $realtime, want.num, want.den, want.err,
                       res_num, res_den, zero_den_error);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_fractions.size();
    end
  end

endmodule

### verif/rational_arithmetic_unit_top_tb.sv
`timescale 1ns / 100ps

module rational_arithmetic_unit_top_tb;
  import rau_pkg::*;

  localparam logic [2:0] CMD_REDUCE   = 3'd5;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int PHASE_ITEMS   = 170;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 200;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic [2:0]                        command;
  logic signed [OPERAND_WIDTH-1:0]   a_num;
  logic signed [OPERAND_WIDTH-1:0]   a_den;
  logic signed [OPERAND_WIDTH-1:0]   b_num;
  logic signed [OPERAND_WIDTH-1:0]   b_den;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [NUM_W-1:0]           res_num;
  logic [DEN_W-1:0]                  res_den;
  logic                              zero_den_error;

  int fail_count;
  int pending;
  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_req;
  bit hold_done;

  rational_arithmetic_unit_top DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .a_num          (a_num),
    .a_den          (a_den),
    .b_num          (b_num),
    .b_den          (b_den),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res_num        (res_num),
    .res_den        (res_den),
    .zero_den_error (zero_den_error)
  );

  rational_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .a_num          (a_num),
    .a_den          (a_den),
    .b_num          (b_num),
    .b_den          (b_den),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res_num        (res_num),
    .res_den        (res_den),
    .zero_den_error (zero_den_error),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Small values give plenty of common factors; the full range and the edge codes
  // exercise every bit and the widest products.
  function automatic int random_operand();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      return int'($urandom_range(40)) - 20;
    end else if (pick < 80) begin
      return int'($urandom_range(65535)) - 32768;
    end
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return 32767;
      4: return -32767;
      default: return -32768;
    endcase
  endfunction

  // Called in the time step of a rising edge; returns in the step of the accepting edge.
  task automatic offer(
    input logic [2:0] cmd,
    input int         an,
    input int         ad,
    input int         bn,
    input int         bd
  );
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    a_num    <= OPERAND_WIDTH'(an);
    a_den    <= OPERAND_WIDTH'(ad);
    b_num    <= OPERAND_WIDTH'(bn);
    b_den    <= OPERAND_WIDTH'(bd);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_random();
    logic [2:0] cmd;
    if ($urandom_range(9) == 0) begin
      cmd = 3'($urandom_range(7, 6));
    end else begin
      cmd = 3'($urandom_range(5));
    end
    offer(cmd, random_operand(), random_operand(), random_operand(), random_operand());
  endtask

  // Receiver side. A hold request keeps out_ready low long enough for the unit to
  // fill its output register and stop taking requests.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    #30_000_000;
    $display("rational_arithmetic_unit_top_tb: done, errors");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_ADD;
    a_num = '0;
    a_den = '0;
    b_num = '0;
    b_den = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    offer(CMD_ADD, 1, 2, 1, 3);
    offer(CMD_SUB, 3, 4, 3, 4);
    offer(CMD_SUB, -32767, 1, 32767, 1);
    offer(CMD_MUL, 32767, -32767, -32767, 32767);
    offer(CMD_MUL, 32767, 32766, 32765, 32764);
    offer(CMD_DIV, 5, 7, 0, 3);
    offer(CMD_DIV, -6, 35, 9, -14);
    offer(CMD_DIV, 32767, 1, 1, 32767);
    offer(CMD_ADD, 1, 0, 1, 1);
    offer(CMD_MUL, 0, 5, 7, 0);
    offer(CMD_NEG, -32767, -1, random_operand(), random_operand());
    offer(CMD_NEG, 0, 9, random_operand(), random_operand());
    offer(CMD_NEG, 5, 0, random_operand(), random_operand());
    offer(CMD_REDUCE, 6, -4, random_operand(), random_operand());
    offer(CMD_REDUCE, 0, -5, random_operand(), random_operand());
    offer(CMD_REDUCE, 7, 0, random_operand(), random_operand());
    offer(CMD_SPARE_LO, 12, 18, random_operand(), random_operand());
    offer(CMD_SPARE_HI, -15, -25, random_operand(), random_operand());
    // Most negative operand codes.
    offer(CMD_ADD, -32768, -32768, -32768, -32768);
    offer(CMD_MUL, -32768, 1, -32768, -1);
    offer(CMD_ADD, -32768, 32767, -32768, 32765);
    offer(CMD_SUB, -32768, -1, 32767, 1);
    offer(CMD_REDUCE, -32768, 3, 0, 0);

    repeat (PHASE_ITEMS) offer_random();

    sender_idle_pct = 85;
    repeat (PHASE_ITEMS) offer_random();

    sender_idle_pct = 0;
    receiver_stall_pct = 85;
    repeat (PHASE_ITEMS) offer_random();

    sender_idle_pct = 18;
    receiver_stall_pct = 18;
    repeat (PHASE_ITEMS) offer_random();

    // Back-to-back requests against a receiver that holds off.
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_req = 1'b1;
    repeat (12) offer_random();

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("rational_arithmetic_unit_top_tb: done, clean");
    end else begin
      $display("rational_arithmetic_unit_top_tb: done, errors");
    end
    $finish;
  end

endmodule
